### rtl/core/segment_tilt_angle_defines.svh
// Assertion macros used by the sta_checker file of the segment tilt block.
// Every macro expects a clock clk_i and an active-low reset rst_ni in scope.
`ifndef SEGMENT_TILT_ANGLE_DEFINES_SVH
`define SEGMENT_TILT_ANGLE_DEFINES_SVH

// Property that must hold in the same cycle as its condition.
`define STA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Property whose consequence is checked in the cycle after its condition.
`define STA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sta_pkg.sv
// Package for the segment tilt block: widths, angle constants, arctangent table
// and the record passed along the CORDIC cell chain. No dependencies.
package sta_pkg;

  localparam int COORD_BITS      = 12;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int CORDIC_STAGES   = 14;
  localparam int GUARD_BITS      = 8;

  localparam int DIFF_W   = COORD_BITS + 1;
  localparam int VEC_W    = COORD_BITS + GUARD_BITS + 3;
  localparam int ANG_W    = ANGLE_FRAC_BITS + 3;
  localparam int RES_W    = ANGLE_FRAC_BITS + 5;
  localparam int OFFSET_W = 15;
  localparam int TILT_W   = 16;
  localparam int STAGE_W  = $clog2(CORDIC_STAGES);

  // Registers between input and output: entry stage, the cells, output stage.
  localparam int PIPE_DEPTH = CORDIC_STAGES + 2;
  localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint Q30_PI      = 64'sd3373259426;

  // Rounds a Q30 constant to nearest, ties up, into the angle format.
  function automatic longint q30_to_angle(longint v);
    longint sh;
    sh = 30 - ANGLE_FRAC_BITS;
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint atan_q30(int i);
    longint r;
    case (i)
      0:       r = 64'sd843314857;
      1:       r = 64'sd497837829;
      2:       r = 64'sd263043837;
      3:       r = 64'sd133525159;
      4:       r = 64'sd67021687;
      5:       r = 64'sd33543516;
      6:       r = 64'sd16775851;
      7:       r = 64'sd8388437;
      8:       r = 64'sd4194283;
      9:       r = 64'sd2097149;
      10:      r = 64'sd1048576;
      11:      r = 64'sd524288;
      12:      r = 64'sd262144;
      13:      r = 64'sd131072;
      14:      r = 64'sd65536;
      15:      r = 64'sd32768;
      16:      r = 64'sd16384;
      17:      r = 64'sd8192;
      18:      r = 64'sd4096;
      19:      r = 64'sd2048;
      20:      r = 64'sd1024;
      21:      r = 64'sd512;
      22:      r = 64'sd256;
      23:      r = 64'sd128;
      default: r = 64'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [ANG_W-1:0] atan_angle(int i);
    return ANG_W'(q30_to_angle(atan_q30(i)));
  endfunction

  localparam logic signed [RES_W-1:0] HALF_PI = RES_W'(q30_to_angle(Q30_HALF_PI));
  localparam logic signed [RES_W-1:0] PI      = RES_W'(q30_to_angle(Q30_PI));

  typedef enum logic [1:0] {
    KIND_GENERAL,
    KIND_HORIZ,
    KIND_VERT
  } seg_kind_e;

  typedef struct packed {
    seg_kind_e                kind;
    logic signed [VEC_W-1:0]  x;
    logic signed [VEC_W-1:0]  y;
    logic signed [ANG_W-1:0]  z;
  } cordic_data_t;

endpackage

### rtl/core/sta_seg_if.sv
// Segment input channel: valid/ready handshake with four pixel coordinates.
// Depends on sta_pkg for the coordinate width.
interface sta_seg_if;
  logic                           valid;
  logic                           ready;
  logic [sta_pkg::COORD_BITS-1:0] start_x;
  logic [sta_pkg::COORD_BITS-1:0] start_y;
  logic [sta_pkg::COORD_BITS-1:0] end_x;
  logic [sta_pkg::COORD_BITS-1:0] end_y;

  modport source (output valid, output start_x, output start_y, output end_x,
                  output end_y, input ready);
  modport sink (input valid, input start_x, input start_y, input end_x,
                input end_y, output ready);
endinterface

### rtl/core/sta_tilt_if.sv
// Tilt result channel: valid/ready handshake with one signed angle.
// Depends on sta_pkg for the angle width.
interface sta_tilt_if;
  logic                              valid;
  logic                              ready;
  logic signed [sta_pkg::TILT_W-1:0] tilt_angle;

  modport source (output valid, output tilt_angle, input ready);
  modport sink (input valid, input tilt_angle, output ready);
endinterface

### rtl/core/sta_prep.sv
// Entry stage: coordinate differences, special-case detection and the
// scaled starting vector for the CORDIC chain. Depends on sta_pkg.
module sta_prep (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic [sta_pkg::COORD_BITS-1:0] start_x_i,
  input  logic [sta_pkg::COORD_BITS-1:0] start_y_i,
  input  logic [sta_pkg::COORD_BITS-1:0] end_x_i,
  input  logic [sta_pkg::COORD_BITS-1:0] end_y_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output sta_pkg::cordic_data_t          data_o
);

  logic signed [sta_pkg::DIFF_W-1:0] dx, dy, adx, ady;
  logic signed [sta_pkg::VEC_W-1:0]  x_ext, y_ext;
  sta_pkg::cordic_data_t             data_d, data_q;
  logic                              valid_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    dx = $signed({1'b0, end_x_i}) - $signed({1'b0, start_x_i});
    dy = $signed({1'b0, end_y_i}) - $signed({1'b0, start_y_i});
    // Turning the vector into the right half-plane leaves dy/dx unchanged.
    adx = dx[sta_pkg::DIFF_W-1] ? -dx : dx;
    ady = dx[sta_pkg::DIFF_W-1] ? -dy : dy;
    x_ext = sta_pkg::VEC_W'(adx);
    y_ext = sta_pkg::VEC_W'(ady);
    data_d.x = x_ext <<< sta_pkg::GUARD_BITS;
    data_d.y = y_ext <<< sta_pkg::GUARD_BITS;
    data_d.z = '0;
    if (dy == '0) begin
      data_d.kind = sta_pkg::KIND_HORIZ;
    end else if (dx == '0) begin
      data_d.kind = sta_pkg::KIND_VERT;
    end else begin
      data_d.kind = sta_pkg::KIND_GENERAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### rtl/core/sta_cordic_cell.sv
// One CORDIC vectoring cell: a micro-rotation by atan(2^-stage) towards y = 0.
// Depends on sta_pkg for the record type and the arctangent table.
module sta_cordic_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [sta_pkg::STAGE_W-1:0]  stage_i,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  sta_pkg::cordic_data_t        data_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output sta_pkg::cordic_data_t        data_o
);

  logic signed [sta_pkg::VEC_W-1:0] xs, ys;
  logic signed [sta_pkg::ANG_W-1:0] step_angle;
  sta_pkg::cordic_data_t            data_d, data_q;
  logic                             valid_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    // Arithmetic right shift rounds towards minus infinity.
    xs = data_i.x >>> stage_i;
    ys = data_i.y >>> stage_i;
    step_angle = sta_pkg::atan_angle(int'(stage_i));
    data_d.kind = data_i.kind;
    if (!data_i.y[sta_pkg::VEC_W-1]) begin
      data_d.x = data_i.x + ys;
      data_d.y = data_i.y - xs;
      data_d.z = data_i.z + step_angle;
    end else begin
      data_d.x = data_i.x - ys;
      data_d.y = data_i.y + xs;
      data_d.z = data_i.z - step_angle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### rtl/core/sta_post.sv
// Output stage: turns the arctangent into a tilt from vertical, folds it,
// removes the offset (general kind only), holds it. Depends on sta_pkg.
module sta_post (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  sta_pkg::cordic_data_t                data_i,
  input  logic signed [sta_pkg::OFFSET_W-1:0]  offset_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic signed [sta_pkg::TILT_W-1:0]    tilt_o
);

  logic signed [sta_pkg::RES_W-1:0]  ang, folded, general;
  logic signed [sta_pkg::TILT_W-1:0] tilt_d, tilt_q;
  logic                              valid_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    ang     = sta_pkg::HALF_PI - sta_pkg::RES_W'(data_i.z);
    folded  = (ang > sta_pkg::HALF_PI) ? ang - sta_pkg::PI : ang;
    general = folded - sta_pkg::RES_W'(offset_i);
    case (data_i.kind)
      sta_pkg::KIND_HORIZ: tilt_d = sta_pkg::HALF_PI[sta_pkg::TILT_W-1:0];
      sta_pkg::KIND_VERT:  tilt_d = '0;
      default:             tilt_d = general[sta_pkg::TILT_W-1:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      tilt_q <= tilt_d;
    end
  end

  assign valid_o = valid_q;
  assign tilt_o  = tilt_q;

endmodule

### rtl/core/segment_tilt_angle.sv
// Segment tilt from vertical: entry stage, a chain of CORDIC_STAGES vectoring
// cells and an output stage. One segment per cycle while results are taken;
// every stage may stall on its own, so empty stages keep accepting while a
// result waits at the output.
// Reset clears all stage valid flags and sets the angle offset to zero.
module segment_tilt_angle (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic signed [sta_pkg::OFFSET_W-1:0] cfg_wdata_i,
  sta_seg_if.sink                             seg_i,
  sta_tilt_if.source                          tilt_o
);

  logic signed [sta_pkg::OFFSET_W-1:0] offset_q;
  logic                                valid_c [sta_pkg::CORDIC_STAGES+1];
  logic                                ready_c [sta_pkg::CORDIC_STAGES+1];
  sta_pkg::cordic_data_t               data_c  [sta_pkg::CORDIC_STAGES+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  sta_prep u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (seg_i.valid),
    .ready_o   (seg_i.ready),
    .start_x_i (seg_i.start_x),
    .start_y_i (seg_i.start_y),
    .end_x_i   (seg_i.end_x),
    .end_y_i   (seg_i.end_y),
    .valid_o   (valid_c[0]),
    .ready_i   (ready_c[0]),
    .data_o    (data_c[0])
  );

  for (genvar g = 0; g < sta_pkg::CORDIC_STAGES; g++) begin : g_cell
    sta_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (sta_pkg::STAGE_W'(g)),
      .valid_i (valid_c[g]),
      .ready_o (ready_c[g]),
      .data_i  (data_c[g]),
      .valid_o (valid_c[g+1]),
      .ready_i (ready_c[g+1]),
      .data_o  (data_c[g+1])
    );
  end

  sta_post u_post (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_c[sta_pkg::CORDIC_STAGES]),
    .ready_o  (ready_c[sta_pkg::CORDIC_STAGES]),
    .data_i   (data_c[sta_pkg::CORDIC_STAGES]),
    .offset_i (offset_q),
    .valid_o  (tilt_o.valid),
    .ready_i  (tilt_o.ready),
    .tilt_o   (tilt_o.tilt_angle)
  );

endmodule

### rtl/core/sta_checker.sv
// Port-level checker for the segment tilt block, bound to its top level.
// Depends on sta_pkg and the assertion macros in segment_tilt_angle_defines.svh.
`include "segment_tilt_angle_defines.svh"

module sta_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              seg_valid_i,
  input logic                              seg_ready_i,
  input logic                              tilt_valid_i,
  input logic                              tilt_ready_i,
  input logic signed [sta_pkg::TILT_W-1:0] tilt_angle_i
);

  logic                      seg_xfer, tilt_xfer;
  logic [sta_pkg::CNT_W-1:0] inflight_q;

  assign seg_xfer  = seg_valid_i && seg_ready_i;
  assign tilt_xfer = tilt_valid_i && tilt_ready_i;

  // Number of segments taken in whose results have not yet been transferred.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (seg_xfer && !tilt_xfer) begin
      inflight_q <= inflight_q + 1'b1;
    end else if (tilt_xfer && !seg_xfer) begin
      inflight_q <= inflight_q - 1'b1;
    end
  end

  `STA_ASSERT_NEXT(a_tilt_held, tilt_valid_i && !tilt_ready_i, $stable(tilt_angle_i), "tilt changed while stalled")
  `STA_ASSERT_IMPL(a_ready_when_empty, !tilt_valid_i, seg_ready_i, "input blocked with output stage empty")
  `STA_ASSERT_IMPL(a_no_phantom, tilt_valid_i, inflight_q != '0, "result without a pending segment")
  `STA_ASSERT_IMPL(a_capacity, 1'b1, inflight_q <= sta_pkg::CNT_W'(sta_pkg::PIPE_DEPTH), "more segments held than stages")

endmodule

bind segment_tilt_angle sta_checker u_sta_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .seg_valid_i  (seg_i.valid),
  .seg_ready_i  (seg_i.ready),
  .tilt_valid_i (tilt_o.valid),
  .tilt_ready_i (tilt_o.ready),
  .tilt_angle_i (tilt_o.tilt_angle)
);

### sim/segment_tilt_angle_checker.sv
// Checker for the segment tilt block: watches the segment and tilt channels and
// the offset register port, predicts every tilt and compares it on transfer.
// Depends on sta_pkg, sta_seg_if and sta_tilt_if.
module segment_tilt_angle_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic signed [sta_pkg::OFFSET_W-1:0] cfg_wdata_i,
  sta_seg_if                                  seg,
  sta_tilt_if                                 tilt,
  output int unsigned                         mismatch_count_o,
  output int unsigned                         awaited_o
);

  localparam int     STAGES      = sta_pkg::CORDIC_STAGES;
  localparam int     GUARD       = sta_pkg::GUARD_BITS;
  localparam int     Q_SHIFT     = 30 - sta_pkg::ANGLE_FRAC_BITS;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint PI_Q30      = 64'sd3373259426;

  // Arctangent of 2^-i in Q30.
  localparam longint ATAN_Q30 [0:23] = '{
    64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
    64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
    64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
    64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768,
    64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
    64'sd1024,      64'sd512,       64'sd256,       64'sd128
  };

  logic signed [sta_pkg::TILT_W-1:0]   expected_tilt_q [$];
  logic signed [sta_pkg::OFFSET_W-1:0] tilt_offset;
  int unsigned                         mismatches;

  function automatic longint to_angle(longint q30);
    return (q30 + (longint'(1) <<< (Q_SHIFT - 1))) >>> Q_SHIFT;
  endfunction

  function automatic logic signed [sta_pkg::TILT_W-1:0] predict_tilt(
    logic [sta_pkg::COORD_BITS-1:0]      sx,
    logic [sta_pkg::COORD_BITS-1:0]      sy,
    logic [sta_pkg::COORD_BITS-1:0]      ex,
    logic [sta_pkg::COORD_BITS-1:0]      ey,
    logic signed [sta_pkg::OFFSET_W-1:0] offset
  );
    longint dx, dy, x, y, z, xs, ys, step, half_pi, ang;
    half_pi = to_angle(HALF_PI_Q30);
    dx = longint'(ex) - longint'(sx);
    dy = longint'(ey) - longint'(sy);
    if (dy == 0) begin
      return sta_pkg::TILT_W'(half_pi);
    end
    if (dx == 0) begin
      return '0;
    end
    // Mirror into the right half plane; the ratio dy/dx is unchanged.
    if (dx < 0) begin
      dx = -dx;
      dy = -dy;
    end
    x = dx * (longint'(1) <<< GUARD);
    y = dy * (longint'(1) <<< GUARD);
    z = 0;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      xs   = x >>> i;
      ys   = y >>> i;
      step = to_angle(ATAN_Q30[i]);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + step;
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - step;
      end
    end
    ang = half_pi - z;
    if (ang > half_pi) begin
      ang = ang - to_angle(PI_Q30);
    end
    return sta_pkg::TILT_W'(ang - longint'(offset));
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t tilt mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  initial begin
    tilt_offset      = '0;
    mismatches       = 0;
    mismatch_count_o = 0;
    awaited_o        = 0;
  end

  always @(posedge clk_i) begin
    logic signed [sta_pkg::TILT_W-1:0] want;
    if (rst_ni) begin
      if (tilt.valid && tilt.ready) begin
        if (expected_tilt_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with none outstanding", tilt.tilt_angle));
        end else begin
          want = expected_tilt_q.pop_front();
          if (tilt.tilt_angle !== want) begin
            report_mismatch($sformatf("tilt_angle got %0d want %0d", tilt.tilt_angle, want));
          end
        end
      end
      if (seg.valid && seg.ready) begin
        expected_tilt_q.push_back(predict_tilt(seg.start_x, seg.start_y, seg.end_x,
                                               seg.end_y, tilt_offset));
      end
      // Writes must happen only with the pipeline empty; the block does not enforce
      // it, and then no segment in flight can see the new offset.
      if (cfg_we_i) begin
        tilt_offset = cfg_wdata_i;
      end
    end
    mismatch_count_o <= mismatches;
    awaited_o        <= expected_tilt_q.size();
  end

endmodule

### sim/segment_tilt_angle_tb.sv
// Testbench top for the segment tilt block: clock, reset, segment stimulus,
// offset writes, receiver stalls and the verdict. Depends on sta_pkg, the two
// channel interfaces, segment_tilt_angle and segment_tilt_angle_checker.
module segment_tilt_angle_tb;

  localparam int CB       = sta_pkg::COORD_BITS;
  localparam int CMAX     = (1 << CB) - 1;
  localparam int PHASE_LEN = 58;

  typedef struct packed {
    logic [CB-1:0] sx;
    logic [CB-1:0] sy;
    logic [CB-1:0] ex;
    logic [CB-1:0] ey;
  } segment_t;

  typedef enum int {
    SINK_OPEN,
    SINK_LIGHT,
    SINK_HEAVY,
    SINK_HOLD
  } sink_mode_e;

  logic                                clk_i = 1'b0;
  logic                                rst_ni;
  logic                                cfg_we_i;
  logic signed [sta_pkg::OFFSET_W-1:0] cfg_wdata_i;
  int unsigned                         mismatch_count;
  int unsigned                         awaited;

  sta_seg_if  seg ();
  sta_tilt_if tilt ();

  segment_tilt_angle DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .seg_i       (seg),
    .tilt_o      (tilt)
  );

  segment_tilt_angle_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .seg              (seg),
    .tilt             (tilt),
    .mismatch_count_o (mismatch_count),
    .awaited_o        (awaited)
  );

  always #2 clk_i = ~clk_i;

  function automatic segment_t make_segment(int sx, int sy, int ex, int ey);
    segment_t s;
    s.sx = CB'(sx);
    s.sy = CB'(sy);
    s.ex = CB'(ex);
    s.ey = CB'(ey);
    return s;
  endfunction

  function automatic int near_coord(int c);
    int v;
    v = c + $urandom_range(0, 16) - 8;
    if (v < 0) v = 0;
    if (v > CMAX) v = CMAX;
    return v;
  endfunction

  function automatic int corner_coord();
    return ($urandom_range(0, 1) == 1) ? CMAX : 0;
  endfunction

  function automatic segment_t random_segment();
    int pick, a, b;
    pick = $urandom_range(0, 99);
    a    = $urandom_range(0, CMAX);
    b    = $urandom_range(0, CMAX);
    if (pick < 10) begin
      return make_segment(a, b, $urandom_range(0, CMAX), b);
    end else if (pick < 20) begin
      return make_segment(a, b, a, $urandom_range(0, CMAX));
    end else if (pick < 25) begin
      return make_segment(a, b, a, b);
    end else if (pick < 40) begin
      return make_segment(a, b, near_coord(a), near_coord(b));
    end else if (pick < 50) begin
      return make_segment(corner_coord(), corner_coord(), corner_coord(), corner_coord());
    end
    return make_segment(a, b, $urandom_range(0, CMAX), $urandom_range(0, CMAX));
  endfunction

  // Sends a batch in bursts; valid stays high across back-to-back transfers.
  task automatic send_segments(input segment_t batch[$]);
    int burst_left, gap;
    burst_left = $urandom_range(1, 24);
    foreach (batch[k]) begin
      seg.valid   <= 1'b1;
      seg.start_x <= batch[k].sx;
      seg.start_y <= batch[k].sy;
      seg.end_x   <= batch[k].ex;
      seg.end_y   <= batch[k].ey;
      @(posedge clk_i);
      while (!seg.ready) @(posedge clk_i);
      burst_left--;
      gap = 0;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (k == batch.size() - 1) begin
        seg.valid <= 1'b0;
      end else if (gap > 0) begin
        seg.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // The outstanding count is registered, so look only after the next edge.
  task automatic wait_drained();
    @(posedge clk_i);
    while (awaited != 0) @(posedge clk_i);
  endtask

  task automatic write_offset(input logic signed [sta_pkg::OFFSET_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : sink_pattern
    sink_mode_e  mode;
    int unsigned mode_left;
    int unsigned hold_cnt;
    mode      = SINK_OPEN;
    mode_left = 0;
    hold_cnt  = 0;
    tilt.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode      = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      hold_cnt++;
      case (mode)
        SINK_OPEN:  tilt.ready <= 1'b1;
        SINK_LIGHT: tilt.ready <= ($urandom_range(0, 3) != 0);
        SINK_HEAVY: tilt.ready <= ($urandom_range(0, 3) == 0);
        default:    tilt.ready <= ((hold_cnt % 16) >= 12);
      endcase
    end
  end

  initial begin : stimulus
    segment_t                            batch[$];
    logic signed [sta_pkg::OFFSET_W-1:0] offsets[$];
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    seg.valid   <= 1'b0;
    seg.start_x <= '0;
    seg.start_y <= '0;
    seg.end_x   <= '0;
    seg.end_y   <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed segments at the reset offset of zero.
    batch.push_back(make_segment(0, 0, 0, 0));
    batch.push_back(make_segment(CMAX, CMAX, CMAX, CMAX));
    batch.push_back(make_segment(0, 0, CMAX, 0));
    batch.push_back(make_segment(CMAX, CMAX, 0, CMAX));
    batch.push_back(make_segment(0, 0, 0, CMAX));
    batch.push_back(make_segment(CMAX, CMAX, CMAX, 0));
    batch.push_back(make_segment(0, 0, CMAX, CMAX));
    batch.push_back(make_segment(CMAX, CMAX, 0, 0));
    batch.push_back(make_segment(0, CMAX, CMAX, 0));
    batch.push_back(make_segment(CMAX, 0, 0, CMAX));
    batch.push_back(make_segment(0, 0, 1, CMAX));
    batch.push_back(make_segment(0, 0, CMAX, 1));
    batch.push_back(make_segment(0, 1, CMAX, 0));
    batch.push_back(make_segment(CMAX, 0, 0, 1));
    batch.push_back(make_segment(1, CMAX, 0, 0));
    batch.push_back(make_segment(0, 0, 1, 1));
    batch.push_back(make_segment(0, 1, 1, 0));
    batch.push_back(make_segment(5, 7, 3, 9));
    batch.push_back(make_segment(12'hAAA, 12'h555, 12'h555, 12'hAAA));
    batch.push_back(make_segment(12'h555, 12'hAAA, 12'hAAA, 12'h555));
    batch.push_back(make_segment(100, 200, 100, 201));
    batch.push_back(make_segment(300, 40, 299, 40));
    send_segments(batch);
    wait_drained();

    // Offset extremes, the full register range beyond them, random, then zero.
    offsets = '{15'sd12868, -15'sd12868, 15'sd16383, -15'sd16384, '0, '0, '0};
    offsets[4] = sta_pkg::OFFSET_W'($urandom_range(0, 32767));
    offsets[5] = sta_pkg::OFFSET_W'($urandom_range(0, 32767));
    foreach (offsets[p]) begin
      write_offset(offsets[p]);
      batch.delete();
      repeat (PHASE_LEN) batch.push_back(random_segment());
      send_segments(batch);
      wait_drained();
    end

    repeat (sta_pkg::PIPE_DEPTH + 8) @(posedge clk_i);
    if (mismatch_count == 0 && awaited == 0) begin
      $display("segment_tilt_angle verification clean");
    end else begin
      $display("segment_tilt_angle verification failed");
    end
    $finish;
  end

  initial begin : run_limit
    #2000000;
    $display("segment_tilt_angle verification failed");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/sta_pkg.sv
rtl/core/sta_seg_if.sv
rtl/core/sta_tilt_if.sv
rtl/core/sta_prep.sv
rtl/core/sta_cordic_cell.sv
rtl/core/sta_post.sv
rtl/core/segment_tilt_angle.sv
rtl/core/sta_checker.sv
sim/segment_tilt_angle_checker.sv
sim/segment_tilt_angle_tb.sv
